// ===== hdl/mcba_pkg.sv =====
`default_nettype none

package mcba_pkg;

  // width of one sample and of one average
  localparam int unsigned SAMPLE_W = 8;
  // channel fields carried on each stream
  localparam int unsigned PORT_CH  = 3;
  localparam int unsigned DATA_W   = SAMPLE_W * PORT_CH;

  // load enables for the two register stages of a divider lane
  typedef struct packed {
    logic ld_abs;
    logic ld_prod;
  } mcba_en_t;

endpackage

`default_nettype wire

// ===== hdl/mcba_div.sv =====
`default_nettype none

// Signed sum / WINDOW, truncated toward zero, by reciprocal multiply.
// Magnitude and sign are registered, then the product; the quotient
// is formed combinationally from the product register.
module mcba_div #(
  parameter int unsigned WINDOW = 250,
  parameter int unsigned SUM_W  = 16
) (
  input  wire logic                          clk,
  input  wire mcba_pkg::mcba_en_t            en,
  input  wire logic signed [SUM_W-1:0]       sum_i,
  output logic [mcba_pkg::SAMPLE_W-1:0]      q_o
);
  import mcba_pkg::*;

  // exact for every magnitude below 2**SUM_W
  localparam int unsigned SHIFT = SUM_W + $clog2(WINDOW);
  localparam int unsigned MUL_W = SUM_W + 2;
  localparam longint unsigned MUL_L =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MUL_W-1:0] MUL = MUL_W'(MUL_L);
  localparam int unsigned PROD_W = SUM_W + MUL_W;

  logic [SUM_W-1:0]    abs_r;
  logic                neg_a_r;
  logic [PROD_W-1:0]   prod_r;
  logic                neg_p_r;
  logic [PROD_W-1:0]   quo;
  logic [SAMPLE_W-1:0] mag;

  always_ff @(posedge clk) begin
    if (en.ld_abs) begin
      neg_a_r <= sum_i[SUM_W-1];
      abs_r   <= sum_i[SUM_W-1] ? (~sum_i + SUM_W'(1)) : sum_i;
    end
    if (en.ld_prod) begin
      neg_p_r <= neg_a_r;
      prod_r  <= PROD_W'(abs_r) * PROD_W'(MUL);
    end
  end

  always_comb begin
    quo = prod_r >> SHIFT;
    mag = quo[SAMPLE_W-1:0];            // at most 128
    q_o = neg_p_r ? (~mag + SAMPLE_W'(1)) : mag;
  end

endmodule

`default_nettype wire

// ===== hdl/multi_channel_boxcar_average_unit.sv =====
`default_nettype none

// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+--------------------------------------
// in       | in  | in_tvalid / in_tready  | in_tdata  : rssi_ch0, rssi_ch1, rssi_ch2
// out      | out | out_tvalid / out_tready| out_tdata : avg_ch0, avg_ch1, avg_ch2
//
// One item per cycle sustained while out_tready is high; an item's path is
// history read on the accepting edge, then read-modify-write of sums,
// multiply, output reg.
// Reset clears sums, write position and pipeline valids; no clearing pass:
// a first-lap flag makes history rows read as zero until the pointer wraps.
// Stalls on out back up only as far as the first empty stage.
module multi_channel_boxcar_average_unit #(
  parameter int unsigned WINDOW   = 250,
  parameter int unsigned CHANNELS = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [mcba_pkg::DATA_W-1:0]  in_tdata,   // rssi_ch0, rssi_ch1, rssi_ch2
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [mcba_pkg::DATA_W-1:0]       out_tdata   // avg_ch0, avg_ch1, avg_ch2
);
  import mcba_pkg::*;

  localparam int unsigned POS_W = $clog2(WINDOW);
  localparam int unsigned ROW_W = CHANNELS * SAMPLE_W;
  // exact sum of WINDOW signed samples
  localparam int unsigned SUM_W = $clog2(WINDOW * 128) + 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  // history: one row per position, all channels side by side
  logic [ROW_W-1:0] hist_mem [WINDOW];
  logic [ROW_W-1:0] rd_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             lap_r, lap_nxt;     // pointer has wrapped once

  // stage 1: item waiting for its history row
  logic             v1_r;
  logic [POS_W-1:0] pos1_r;
  logic             old_ok1_r;
  logic [ROW_W-1:0] samp1_r;

  logic v2_r, v3_r, ov_r;

  logic signed [SUM_W-1:0] sums_r   [CHANNELS];
  logic signed [SUM_W-1:0] sums_nxt [CHANNELS];
  logic [SAMPLE_W-1:0]     q        [CHANNELS];
  logic [DATA_W-1:0]       out_r;
  logic [DATA_W-1:0]       out_nxt;
  logic [ROW_W-1:0]        samp_in;

  logic adv_o, adv3, adv2, adv1;
  logic acc, mv1, mv2, mv3;
  mcba_en_t en;

  // per-stage advance: a stage moves when the one after it is free or moving
  always_comb begin
    adv_o     = !ov_r || out_tready;
    adv3      = !v3_r || adv_o;
    adv2      = !v2_r || adv3;
    adv1      = !v1_r || adv2;
    in_tready = adv1;
    acc       = in_tvalid && adv1;
    mv1       = v1_r && adv2;
    mv2       = v2_r && adv3;
    mv3       = v3_r && adv_o;
    en.ld_abs  = mv1;
    en.ld_prod = mv2;
  end

  // channels beyond the port fields see zero samples
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < PORT_CH) samp_in[c*SAMPLE_W +: SAMPLE_W] = in_tdata[c*SAMPLE_W +: SAMPLE_W];
      else             samp_in[c*SAMPLE_W +: SAMPLE_W] = '0;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    lap_nxt = lap_r;
    if (acc) begin
      if (pos_r == POS_LAST) begin
        pos_nxt = '0;
        lap_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // running sums: drop the leaving sample, add the new one
  always_comb begin
    logic [SAMPLE_W-1:0] old_s;
    logic [SAMPLE_W-1:0] new_s;
    old_s = '0;
    new_s = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      old_s = old_ok1_r ? rd_r[c*SAMPLE_W +: SAMPLE_W] : '0;
      new_s = samp1_r[c*SAMPLE_W +: SAMPLE_W];
      sums_nxt[c] = sums_r[c]
                  - {{(SUM_W-SAMPLE_W){old_s[SAMPLE_W-1]}}, old_s}
                  + {{(SUM_W-SAMPLE_W){new_s[SAMPLE_W-1]}}, new_s};
    end
  end

  // history memory: read on accept, write back when stage 1 moves on
  always_ff @(posedge clk) begin
    if (acc) rd_r <= hist_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (mv1) hist_mem[pos1_r] <= samp1_r;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pos1_r    <= pos_r;
      old_ok1_r <= lap_r;
      samp1_r   <= samp_in;
    end
    if (mv3) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      lap_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      ov_r  <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) sums_r[c] <= '0;
    end else begin
      pos_r <= pos_nxt;
      lap_r <= lap_nxt;
      if (acc)      v1_r <= 1'b1;
      else if (mv1) v1_r <= 1'b0;
      if (mv1)      v2_r <= 1'b1;
      else if (mv2) v2_r <= 1'b0;
      if (mv2)      v3_r <= 1'b1;
      else if (mv3) v3_r <= 1'b0;
      if (mv3)             ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      if (mv1) begin
        for (int c = 0; c < CHANNELS; c++) sums_r[c] <= sums_nxt[c];
      end
    end
  end

  // one divider lane per channel
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    mcba_div #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .sum_i (sums_nxt[g]),
      .q_o   (q[g])
    );
  end

  // port fields without a channel behind them stay zero
  for (genvar g = 0; g < PORT_CH; g++) begin : g_out
    if (g < CHANNELS) begin : g_live
      assign out_nxt[g*SAMPLE_W +: SAMPLE_W] = q[g];
    end else begin : g_zero
      assign out_nxt[g*SAMPLE_W +: SAMPLE_W] = '0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  // write-back and the next read never hit the same row
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mv1 && acc) |-> (pos1_r != pos_r))
    else $error("history write and read collide on one row");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && pos_r != POS_LAST) |=> (pos_r == $past(pos_r) + POS_W'(1)))
    else $error("write position did not step by one");

  a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !adv3) |-> (ov_r && !out_tready))
    else $error("multiply stage held without downstream stall");

  a_lap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    lap_r |=> lap_r)
    else $error("first-lap flag dropped without reset");

endmodule

`default_nettype wire
